### hw/rtl/nltok_pkg.sv
// Shared constants, result codes and controller/datapath interface types
// for the numbered line tokenizer. No dependencies.
package nltok_pkg;

  // Sizing
  localparam int MAX_WORD_LEN = 32;
  localparam int MAX_WORDS    = 64;
  localparam int BUF_AW       = $clog2(MAX_WORD_LEN);
  localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
  localparam int WORDS_W      = $clog2(MAX_WORDS + 1);

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int ID_W     = 64;
  localparam int ACCX_W   = ID_W + 4;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ID   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUM  = 2'd2;

  // Line status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_TRUNC    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_ID    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_JUNK     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // input transaction taken this cycle
    logic ld_id;    // load line id result into output register
    logic ld_byte;  // load next word byte, advance replay index
    logic ld_sum;   // load line summary result
    logic last;     // last result of this input
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic do_id;    // accepted byte closes the id token
    logic do_rep;   // accepted byte closes a word to replay
    logic do_sum;   // accepted byte ends the line
    logic rep_end;  // replay index sits on the last byte of the word
  } sts_t;

endpackage

### hw/rtl/numbered_line_tokenizer.sv
// Top level of the numbered line tokenizer: joins controller and datapath.
// Depends on nltok_pkg, nltok_ctrl and nltok_dp.
//
// Line bytes enter one per transaction; the first token is parsed as a
// decimal line id (kind 1), each following word is buffered and replayed
// byte by byte with its slot (kind 0), and the byte flagged end_of_line also
// yields a summary (kind 2). The next input is held off until all results of
// an accepted input have been loaded into the output register, one result per
// cycle while the output is not stalled. A byte that causes no result does
// not hold off the next input; one that closes a word of N bytes yields N
// results (plus 1 for the id or the summary), replayed from the word buffer
// one byte per cycle while the output is not stalled.
module numbered_line_tokenizer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [nltok_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                           end_of_line_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [nltok_pkg::KIND_W-1:0]   kind_o,
  output logic [nltok_pkg::BYTE_W-1:0]   char_out_o,
  output logic [nltok_pkg::SLOT_W-1:0]   word_slot_o,
  output logic                           word_end_o,
  output logic [nltok_pkg::ID_W-1:0]     line_id_o,
  output logic [nltok_pkg::COUNT_W-1:0]  word_count_o,
  output logic [nltok_pkg::STATUS_W-1:0] status_o,
  output logic                           last_o
);

  nltok_pkg::cmd_t cmd;
  nltok_pkg::sts_t sts;

  // Sequencer
  nltok_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Parser, word buffer and output register
  nltok_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (data_byte_i),
    .end_of_line_i (end_of_line_i),
    .kind_o        (kind_o),
    .char_out_o    (char_out_o),
    .word_slot_o   (word_slot_o),
    .word_end_o    (word_end_o),
    .line_id_o     (line_id_o),
    .word_count_o  (word_count_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

### hw/rtl/nltok_dp.sv
// Datapath of the numbered line tokenizer: id parser, word buffer memory,
// line bookkeeping, pending results and the output register. Uses nltok_pkg.
module nltok_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nltok_pkg::cmd_t                cmd_i,
  output nltok_pkg::sts_t                sts_o,
  input  logic [nltok_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                           end_of_line_i,
  output logic [nltok_pkg::KIND_W-1:0]   kind_o,
  output logic [nltok_pkg::BYTE_W-1:0]   char_out_o,
  output logic [nltok_pkg::SLOT_W-1:0]   word_slot_o,
  output logic                           word_end_o,
  output logic [nltok_pkg::ID_W-1:0]     line_id_o,
  output logic [nltok_pkg::COUNT_W-1:0]  word_count_o,
  output logic [nltok_pkg::STATUS_W-1:0] status_o,
  output logic                           last_o
);

  // Line state
  logic                             in_token_q, in_token_d;
  logic                             id_done_q, id_done_d;
  logic                             id_digits_q, id_digits_d;
  logic [nltok_pkg::ID_W-1:0]       id_acc_q, id_acc_d;
  logic [nltok_pkg::STATUS_W-1:0]   id_err_q, id_err_d;
  logic [nltok_pkg::LEN_W-1:0]      wlen_q, wlen_d;
  logic                             overlong_q, overlong_d;
  logic [nltok_pkg::WORDS_W-1:0]    words_q, words_d;

  // Pending results of the accepted byte
  logic [nltok_pkg::ID_W-1:0]       pend_id_q;
  logic [nltok_pkg::STATUS_W-1:0]   pend_id_st_q;
  logic [nltok_pkg::SLOT_W-1:0]     pend_slot_q;
  logic [nltok_pkg::BUF_AW-1:0]     pend_lastidx_q;
  logic [nltok_pkg::COUNT_W-1:0]    pend_cnt_q;
  logic [nltok_pkg::STATUS_W-1:0]   pend_sum_st_q;

  // Word buffer and replay
  logic [nltok_pkg::BYTE_W-1:0]     wbuf_mem [nltok_pkg::MAX_WORD_LEN];
  logic [nltok_pkg::BYTE_W-1:0]     rdata_q;
  logic [nltok_pkg::BUF_AW-1:0]     ridx_q, ridx_d;
  logic                             wr_en;
  logic [nltok_pkg::BUF_AW-1:0]     wr_addr;

  // Output register
  logic [nltok_pkg::KIND_W-1:0]     kind_q;
  logic [nltok_pkg::BYTE_W-1:0]     char_q;
  logic [nltok_pkg::SLOT_W-1:0]     slot_q;
  logic                             wend_q;
  logic [nltok_pkg::ID_W-1:0]       line_id_q;
  logic [nltok_pkg::COUNT_W-1:0]    cnt_q;
  logic [nltok_pkg::STATUS_W-1:0]   stat_q;
  logic                             last_q;

  // Byte decode and id step
  logic                             blank, digit, close_tok, trunc;
  logic                             do_id, do_rep;
  logic [3:0]                       dval;
  logic [nltok_pkg::ACCX_W-1:0]     acc_x, acc10;
  logic                             acc_ovf;
  logic [nltok_pkg::STATUS_W-1:0]   err1, err2;
  logic [nltok_pkg::ID_W-1:0]       acc1;
  logic                             digits1, overlong1;
  logic [nltok_pkg::LEN_W-1:0]      wlen1;
  logic [nltok_pkg::WORDS_W-1:0]    words2;
  logic                             id_done2;
  logic [nltok_pkg::COUNT_W-1:0]    sum_cnt;

  assign blank = (data_byte_i == 8'd32) || (data_byte_i >= 8'd9 && data_byte_i <= 8'd13);
  assign digit = (data_byte_i >= 8'h30) && (data_byte_i <= 8'h39);
  assign dval  = 4'(data_byte_i - 8'h30);

  // acc * 10 + d with four guard bits to catch 64-bit overflow
  assign acc_x   = {4'b0, id_acc_q};
  assign acc10   = (acc_x << 3) + (acc_x << 1) + nltok_pkg::ACCX_W'(dval);
  assign acc_ovf = |acc10[nltok_pkg::ACCX_W-1:nltok_pkg::ID_W];

  assign wr_addr = wlen_q[nltok_pkg::BUF_AW-1:0];

  // Next line state for the accepted byte
  always_comb begin
    err1      = id_err_q;
    acc1      = id_acc_q;
    digits1   = id_digits_q;
    wlen1     = wlen_q;
    overlong1 = overlong_q;
    wr_en     = 1'b0;
    if (!blank) begin
      if (!id_done_q) begin
        if (id_err_q == nltok_pkg::STAT_OK) begin
          if (digit) begin
            if (acc_ovf) begin
              err1 = nltok_pkg::STAT_OVERFLOW;
            end else begin
              acc1    = acc10[nltok_pkg::ID_W-1:0];
              digits1 = 1'b1;
            end
          end else begin
            err1 = id_digits_q ? nltok_pkg::STAT_JUNK : nltok_pkg::STAT_NO_ID;
          end
        end
      end else if (32'(wlen_q) < nltok_pkg::MAX_WORD_LEN) begin
        wr_en = cmd_i.accept;
        wlen1 = wlen_q + nltok_pkg::LEN_W'(1);
      end else begin
        overlong1 = 1'b1;
      end
    end

    close_tok = (blank || end_of_line_i) && (in_token_q || !blank);
    do_id     = close_tok && !id_done_q;
    do_rep    = close_tok && id_done_q && !overlong1 && (wlen1 != '0) &&
                (32'(words_q) < nltok_pkg::MAX_WORDS);
    trunc     = close_tok && id_done_q && !overlong1 && (wlen1 != '0) &&
                (32'(words_q) >= nltok_pkg::MAX_WORDS);
    err2      = (trunc && err1 == nltok_pkg::STAT_OK) ? nltok_pkg::STAT_TRUNC : err1;
    words2    = do_rep ? words_q + nltok_pkg::WORDS_W'(1) : words_q;
    id_done2  = id_done_q || do_id;
    sum_cnt   = (32'(words2) > 32'(nltok_pkg::COUNT_MAX)) ? nltok_pkg::COUNT_MAX
                                                           : nltok_pkg::COUNT_W'(words2);

    in_token_d  = in_token_q || !blank;
    id_done_d   = id_done2;
    id_digits_d = digits1;
    id_acc_d    = acc1;
    id_err_d    = err2;
    wlen_d      = wlen1;
    overlong_d  = overlong1;
    words_d     = words2;
    if (close_tok) begin
      wlen_d     = '0;
      overlong_d = 1'b0;
      in_token_d = 1'b0;
    end
    if (end_of_line_i) begin
      in_token_d  = 1'b0;
      id_done_d   = 1'b0;
      id_digits_d = 1'b0;
      id_acc_d    = '0;
      id_err_d    = nltok_pkg::STAT_OK;
      wlen_d      = '0;
      overlong_d  = 1'b0;
      words_d     = '0;
    end
  end

  assign sts_o.do_id   = do_id;
  assign sts_o.do_rep  = do_rep;
  assign sts_o.do_sum  = end_of_line_i;
  assign sts_o.rep_end = (ridx_q == pend_lastidx_q);

  // Line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_token_q  <= 1'b0;
      id_done_q   <= 1'b0;
      id_digits_q <= 1'b0;
      id_acc_q    <= '0;
      id_err_q    <= nltok_pkg::STAT_OK;
      wlen_q      <= '0;
      overlong_q  <= 1'b0;
      words_q     <= '0;
    end else if (cmd_i.accept) begin
      in_token_q  <= in_token_d;
      id_done_q   <= id_done_d;
      id_digits_q <= id_digits_d;
      id_acc_q    <= id_acc_d;
      id_err_q    <= id_err_d;
      wlen_q      <= wlen_d;
      overlong_q  <= overlong_d;
      words_q     <= words_d;
    end
  end

  // Pending result payloads, captured at accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pend_id_q      <= (err1 == nltok_pkg::STAT_OK) ? acc1 : '0;
      pend_id_st_q   <= err1;
      pend_slot_q    <= nltok_pkg::SLOT_W'(words_q);
      pend_lastidx_q <= nltok_pkg::BUF_AW'(wlen1 - nltok_pkg::LEN_W'(1));
      pend_cnt_q     <= sum_cnt;
      pend_sum_st_q  <= id_done2 ? err2 : nltok_pkg::STAT_NO_ID;
    end
  end

  // Replay index: restarts at each accept, steps on each byte loaded
  always_comb begin
    ridx_d = ridx_q;
    if (cmd_i.accept) begin
      ridx_d = '0;
    end else if (cmd_i.ld_byte) begin
      ridx_d = ridx_q + nltok_pkg::BUF_AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ridx_q <= '0;
    end else begin
      ridx_q <= ridx_d;
    end
  end

  // Word buffer: one write port, one registered read at the next index
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wbuf_mem[wr_addr] <= data_byte_i;
    end
    if (wr_en && (wr_addr == ridx_d)) begin
      rdata_q <= data_byte_i;
    end else begin
      rdata_q <= wbuf_mem[ridx_d];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_id || cmd_i.ld_byte || cmd_i.ld_sum) begin
      kind_q    <= nltok_pkg::KIND_BYTE;
      char_q    <= '0;
      slot_q    <= '0;
      wend_q    <= 1'b0;
      line_id_q <= '0;
      cnt_q     <= '0;
      stat_q    <= nltok_pkg::STAT_OK;
      last_q    <= cmd_i.last;
      if (cmd_i.ld_id) begin
        kind_q    <= nltok_pkg::KIND_ID;
        line_id_q <= pend_id_q;
        stat_q    <= pend_id_st_q;
      end else if (cmd_i.ld_byte) begin
        char_q <= rdata_q;
        slot_q <= pend_slot_q;
        wend_q <= (ridx_q == pend_lastidx_q);
      end else begin
        kind_q <= nltok_pkg::KIND_SUM;
        cnt_q  <= pend_cnt_q;
        stat_q <= pend_sum_st_q;
      end
    end
  end

  assign kind_o       = kind_q;
  assign char_out_o   = char_q;
  assign word_slot_o  = slot_q;
  assign word_end_o   = wend_q;
  assign line_id_o    = line_id_q;
  assign word_count_o = cnt_q;
  assign status_o     = stat_q;
  assign last_o       = last_q;

endmodule

### hw/rtl/nltok_ctrl.sv
// Controller of the numbered line tokenizer: input handshake, result
// sequencing and output valid. Uses nltok_pkg types.
module nltok_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  nltok_pkg::sts_t sts_i,
  output nltok_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ID,
    S_REP,
    S_SUM
  } state_e;

  state_e state_q, state_d;
  logic   rep_pend_q, rep_pend_d;
  logic   sum_pend_q, sum_pend_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencing of results for one accepted byte
  always_comb begin
    state_d     = state_q;
    rep_pend_d  = rep_pend_q;
    sum_pend_d  = sum_pend_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          rep_pend_d   = sts_i.do_rep;
          sum_pend_d   = sts_i.do_sum;
          if (sts_i.do_id) begin
            state_d = S_ID;
          end else if (sts_i.do_rep) begin
            state_d = S_REP;
          end else if (sts_i.do_sum) begin
            state_d = S_SUM;
          end
        end
      end
      S_ID: begin
        if (out_free) begin
          cmd_o.ld_id = 1'b1;
          cmd_o.last  = !rep_pend_q && !sum_pend_q;
          out_valid_d = 1'b1;
          if (rep_pend_q) begin
            state_d = S_REP;
          end else if (sum_pend_q) begin
            state_d = S_SUM;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_REP: begin
        if (out_free) begin
          cmd_o.ld_byte = 1'b1;
          cmd_o.last    = sts_i.rep_end && !sum_pend_q;
          out_valid_d   = 1'b1;
          if (sts_i.rep_end) begin
            state_d = sum_pend_q ? S_SUM : S_IDLE;
          end
        end
      end
      S_SUM: begin
        if (out_free) begin
          cmd_o.ld_sum = 1'b1;
          cmd_o.last   = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rep_pend_q  <= 1'b0;
      sum_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rep_pend_q  <= rep_pend_d;
      sum_pend_q  <= sum_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // A result held under stall is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(cmd_o.ld_id || cmd_o.ld_byte || cmd_o.ld_sum))
    else $error("output register overwritten while stalled");

  // At most one load and never together with an accept
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.ld_id, cmd_o.ld_byte, cmd_o.ld_sum}))
    else $error("conflicting controller commands");

  // The last result of an input returns the controller to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_o.ld_id || cmd_o.ld_byte || cmd_o.ld_sum) && cmd_o.last) |=> state_q == S_IDLE)
    else $error("last result did not end the sequence");

  // A loaded result is presented on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.ld_id || cmd_o.ld_byte || cmd_o.ld_sum) |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

### sim/tb_numbered_line_tokenizer.sv
// Self-checking testbench for numbered_line_tokenizer: a scoreboard class
// predicts every result from the accepted line bytes. Depends on nltok_pkg.
`timescale 1ns / 100ps

module tb_numbered_line_tokenizer;

  localparam int IDLE_PCT       = 35;
  localparam int BYTE_TARGET    = 480;
  // No transaction on either side for this long means the block is hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Longest item: one input plus 33 results.
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [nltok_pkg::KIND_W-1:0]   kind;
    logic [nltok_pkg::BYTE_W-1:0]   ch;
    logic [nltok_pkg::SLOT_W-1:0]   slot;
    logic                           wend;
    logic [nltok_pkg::ID_W-1:0]     id;
    logic [nltok_pkg::COUNT_W-1:0]  cnt;
    logic [nltok_pkg::STATUS_W-1:0] st;
    logic                           last;
  } tok_result_t;

  // Line tokenizer predictor plus queue of results still to arrive
  class token_scoreboard;
    tok_result_t                    pending[$];
    logic [7:0]                     word_buf [nltok_pkg::MAX_WORD_LEN];
    int unsigned                    word_len;
    int unsigned                    words_kept;
    bit                             overlong;
    bit                             id_done;
    bit                             in_tok;
    bit                             seen_digit;
    logic [nltok_pkg::ID_W-1:0]     id_acc;
    logic [nltok_pkg::STATUS_W-1:0] line_status;
    int                             errors;

    function new();
      errors = 0;
      clear_line();
    endfunction

    static function bit is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void clear_line();
      word_len    = 0;
      words_kept  = 0;
      overlong    = 0;
      id_done     = 0;
      in_tok      = 0;
      seen_digit  = 0;
      id_acc      = '0;
      line_status = nltok_pkg::STAT_OK;
    endfunction

    function void add(logic [nltok_pkg::KIND_W-1:0] kind, logic [7:0] ch,
                      logic [nltok_pkg::SLOT_W-1:0] slot, logic wend,
                      logic [nltok_pkg::ID_W-1:0] id, logic [nltok_pkg::COUNT_W-1:0] cnt,
                      logic [nltok_pkg::STATUS_W-1:0] st);
      tok_result_t r;
      r.kind = kind; r.ch = ch; r.slot = slot; r.wend = wend;
      r.id = id; r.cnt = cnt; r.st = st; r.last = 1'b0;
      pending.push_back(r);
    endfunction

    // One accepted line byte: update line state, queue the results it causes
    function void note_byte(logic [7:0] c, logic eol);
      bit                         blank;
      int                         base;
      logic [nltok_pkg::ID_W-1:0] d;
      blank = is_space(c);
      base  = pending.size();
      if (!blank) begin
        in_tok = 1;
        if (!id_done) begin
          if (line_status == nltok_pkg::STAT_OK) begin
            if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
              d = nltok_pkg::ID_W'(c - CH_ZERO);
              if (id_acc > ({nltok_pkg::ID_W{1'b1}} - d) / 10) begin
                line_status = nltok_pkg::STAT_OVERFLOW;
              end else begin
                id_acc     = id_acc * 10 + d;
                seen_digit = 1;
              end
            end else begin
              line_status = seen_digit ? nltok_pkg::STAT_JUNK : nltok_pkg::STAT_NO_ID;
            end
          end
        end else if (word_len < nltok_pkg::MAX_WORD_LEN) begin
          word_buf[word_len] = c;
          word_len++;
        end else begin
          overlong = 1;
        end
      end
      // token close: id result, or replay of a stored word
      if ((blank || eol) && in_tok) begin
        if (!id_done) begin
          id_done = 1;
          add(nltok_pkg::KIND_ID, '0, '0, 1'b0,
              (line_status == nltok_pkg::STAT_OK) ? id_acc : '0, '0, line_status);
        end else if (!overlong && word_len > 0) begin
          if (words_kept >= nltok_pkg::MAX_WORDS) begin
            if (line_status == nltok_pkg::STAT_OK) line_status = nltok_pkg::STAT_TRUNC;
          end else begin
            for (int i = 0; i < word_len; i++)
              add(nltok_pkg::KIND_BYTE, word_buf[i], nltok_pkg::SLOT_W'(words_kept),
                  (i + 1) == word_len, '0, '0, nltok_pkg::STAT_OK);
            words_kept++;
          end
        end
        word_len = 0;
        overlong = 0;
        in_tok   = 0;
      end
      // line end summary
      if (eol) begin
        add(nltok_pkg::KIND_SUM, '0, '0, 1'b0, '0,
            (words_kept > nltok_pkg::COUNT_MAX) ? nltok_pkg::COUNT_MAX
                                                : nltok_pkg::COUNT_W'(words_kept),
            id_done ? line_status : nltok_pkg::STAT_NO_ID);
        clear_line();
      end
      if (pending.size() > base) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(tok_result_t got);
      tok_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d", $time, got.kind);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      cmp("kind", exp_r.kind, got.kind);
      cmp("char_out", exp_r.ch, got.ch);
      cmp("word_slot", exp_r.slot, got.slot);
      cmp("word_end", exp_r.wend, got.wend);
      cmp("line_id", exp_r.id, got.id);
      cmp("word_count", exp_r.cnt, got.cnt);
      cmp("status", exp_r.st, got.st);
      cmp("last", exp_r.last, got.last);
    endfunction

    function bit drained_clean();
      if (pending.size() != 0) begin
        $display("%0t: leftover results: expected %0d more, actual 0", $time,
                 pending.size());
        errors++;
      end
      return errors == 0;
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [nltok_pkg::BYTE_W-1:0]   data_byte;
  logic                           end_of_line;
  logic                           out_valid;
  logic                           out_stall;
  logic [nltok_pkg::KIND_W-1:0]   kind;
  logic [nltok_pkg::BYTE_W-1:0]   char_out;
  logic [nltok_pkg::SLOT_W-1:0]   word_slot;
  logic                           word_end;
  logic [nltok_pkg::ID_W-1:0]     line_id;
  logic [nltok_pkg::COUNT_W-1:0]  word_count;
  logic [nltok_pkg::STATUS_W-1:0] status;
  logic                           last;

  token_scoreboard sb;
  int              in_count;
  int              stuck_cycles;
  int              bytes_sent;
  bit              quiet;
  logic [7:0]      line_q[$];

  numbered_line_tokenizer dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .end_of_line_i(end_of_line),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .kind_o       (kind),
    .char_out_o   (char_out),
    .word_slot_o  (word_slot),
    .word_end_o   (word_end),
    .line_id_o    (line_id),
    .word_count_o (word_count),
    .status_o     (status),
    .last_o       (last)
  );

  always #1 clk = ~clk;

  // Random backpressure on the result side
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Monitor: scoreboard updates and hang watchdog
  always @(posedge clk) begin
    tok_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_byte(data_byte, end_of_line);
        in_count++;
      end
      if (out_valid && !out_stall) begin
        got.kind = kind; got.ch = char_out; got.slot = word_slot; got.wend = word_end;
        got.id = line_id; got.cnt = word_count; got.st = status; got.last = last;
        sb.check_result(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Present one byte, called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eol);
    int snap;
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    end_of_line <= eol;
    snap = in_count;
    do @(negedge clk); while (in_count == snap);
    bytes_sent++;
  endtask

  // Send the assembled line, end_of_line on its final byte
  task automatic flush_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  function automatic logic [7:0] pick_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(9 + k);
  endfunction

  function automatic logic [7:0] pick_word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (token_scoreboard::is_space(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic void push_blanks(int n);
    repeat (n) line_q.push_back(pick_blank());
  endfunction

  function automatic void push_decimal(logic [63:0] v);
    logic [7:0] digs[$];
    do begin
      digs.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) line_q.push_back(digs[i]);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  // Id token: mostly valid decimals, also the max value, overflow, junk and no id
  function automatic void push_id(int pick);
    if (pick < 70) begin
      push_decimal({$urandom, $urandom} >> $urandom_range(0, 63));
    end else if (pick < 78) begin
      push_decimal('1);
    end else if (pick < 85) begin
      if ($urandom_range(0, 1)) push_text("18446744073709551616");
      else repeat ($urandom_range(21, 25)) line_q.push_back(pick_digit());
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 4)) line_q.push_back(pick_digit());
      repeat ($urandom_range(1, 3)) line_q.push_back(pick_word_char());
    end else begin
      case ($urandom_range(0, 2))
        0:       line_q.push_back(8'h2D);
        1:       line_q.push_back(8'h2B);
        default: line_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
      endcase
      repeat ($urandom_range(0, 3)) line_q.push_back(pick_digit());
    end
  endfunction

  function automatic int pick_word_len();
    int lens[4] = '{nltok_pkg::MAX_WORD_LEN - 1, nltok_pkg::MAX_WORD_LEN,
                    nltok_pkg::MAX_WORD_LEN + 1, nltok_pkg::MAX_WORD_LEN + 8};
    if ($urandom_range(0, 99) < 15) return lens[$urandom_range(0, 3)];
    return $urandom_range(1, 8);
  endfunction

  // Build one random line of the given shape
  function automatic void build_line(int form);
    int nwords;
    if (form < 6) begin
      // empty line: blanks only
      push_blanks($urandom_range(1, 4));
    end else if (form < 14) begin
      // noise: arbitrary bytes
      repeat ($urandom_range(1, 30)) line_q.push_back(8'($urandom_range(0, 255)));
    end else if (form < 20) begin
      // past the slot limit with one-byte words
      push_decimal(64'($urandom_range(0, 9999)));
      repeat (nltok_pkg::MAX_WORDS + $urandom_range(1, 4)) begin
        push_blanks(1);
        line_q.push_back(pick_word_char());
      end
    end else begin
      push_blanks($urandom_range(0, 1));
      push_id($urandom_range(0, 99));
      nwords = $urandom_range(0, 6);
      repeat (nwords) begin
        push_blanks($urandom_range(1, 2));
        repeat (pick_word_len()) line_q.push_back(pick_word_char());
      end
      if ($urandom_range(0, 1)) push_blanks($urandom_range(1, 2));
    end
  endfunction

  initial begin
    int forced[4] = '{14, 40, 50, 100};
    int line_no;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    data_byte   = '0;
    end_of_line = 1'b0;
    out_stall   = 1'b0;
    quiet       = 1'b0;
    in_count    = 0;
    bytes_sent  = 0;
    stuck_cycles = 0;
    sb = new();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty line
    line_q = '{CH_SPACE};
    flush_line();
    // sign in place of the id
    line_q = '{8'h2D, 8'h35};
    flush_line();
    // junk after digits, then a one-byte word closed by the line end
    line_q = '{8'h34, 8'h78, CH_SPACE, 8'h39};
    flush_line();
    // id zero, word with the byte extremes
    line_q = '{CH_ZERO, 8'd9, 8'hFF, 8'h00};
    flush_line();
    // id closed by a blank that ends the line
    line_q = '{8'h33, 8'd13};
    flush_line();
    // vertical tab, form feed and line feed as separators, trailing space ends the line
    line_q = '{8'h37, 8'd11, 8'h61, 8'd12, 8'd10, 8'h62, CH_SPACE};
    flush_line();

    // Random lines; the first few force slot limit, id overflow and overlong words
    line_no = 0;
    while (bytes_sent < BYTE_TARGET) begin
      quiet = (bytes_sent >= 200 && bytes_sent < 300);
      if (line_no < 2) build_line(forced[line_no]);
      else if (line_no < 4) begin
        push_id(forced[line_no] == 40 ? 75 : 80);
        push_blanks(1);
        repeat (nltok_pkg::MAX_WORD_LEN + line_no - 2) line_q.push_back(pick_word_char());
      end else build_line($urandom_range(0, 99));
      flush_line();
      line_no++;
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // Drain, then let any extra results appear before the verdict
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.drained_clean()) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
